// File: sv/sha1md_pkg.sv
package sha1md_pkg;

	localparam int unsigned NumWords = 5;
	localparam int unsigned WinWords = 16;
	localparam int unsigned Rounds   = 80;
	localparam int unsigned RndW     = $clog2(Rounds);
	localparam int unsigned IdxW     = 3;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [7:0] PadMark = 8'h80;

	// Round groups of twenty rounds each.
	typedef enum logic [1:0] {
		PH_CHOOSE = 2'd0,
		PH_PARITY = 2'd1,
		PH_MAJOR  = 2'd2,
		PH_LATE   = 2'd3
	} phase_t;

	// Source of the byte shifted into the block window.
	typedef enum logic [1:0] {
		SRC_MSG  = 2'd0,
		SRC_PAD  = 2'd1,
		SRC_ZERO = 2'd2,
		SRC_LEN  = 2'd3
	} src_t;

	typedef struct packed {
		logic            shift;
		src_t            src;
		logic            count_len;
		logic            load;
		logic            round;
		phase_t          phase;
		logic            fin;
		logic            reinit;
		logic [IdxW-1:0] word_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic last_slot;
		logic at_len;
	} dp_stat_t;

	function automatic logic [31:0] init_word(input logic [IdxW-1:0] idx);
		logic [31:0] r;
		case (idx)
			3'd0:    r = H0;
			3'd1:    r = H1;
			3'd2:    r = H2;
			3'd3:    r = H3;
			default: r = H4;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input phase_t ph);
		logic [31:0] r;
		case (ph)
			PH_CHOOSE: r = K0;
			PH_PARITY: r = K1;
			PH_MAJOR:  r = K2;
			default:   r = K3;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_f(input phase_t ph, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] r;
		case (ph)
			PH_CHOOSE: r = (b & c) | (~b & d);
			PH_MAJOR:  r = (b & c) | (b & d) | (c & d);
			default:   r = b ^ c ^ d;
		endcase
		return r;
	endfunction

endpackage

// File: sv/sha1md_if.sv
interface sha1md_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source(output valid, output msg_byte, output byte_present,
		output end_of_message, input ready);
	modport sink(input valid, input msg_byte, input byte_present,
		input end_of_message, output ready);
endinterface

interface sha1md_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source(output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink(input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

// File: sv/sha1md_dp.sv
module sha1md_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sha1md_pkg::dp_cmd_t cmd,
	input  logic [7:0]          msg_byte,
	output sha1md_pkg::dp_stat_t stat,
	output logic [31:0]         digest_word
);

	logic [6:0]  fill_q;
	logic [63:0] len_q;
	logic [31:0] chain_q [sha1md_pkg::NumWords];
	logic [31:0] rv_q    [sha1md_pkg::NumWords];
	logic [31:0] win_q   [sha1md_pkg::WinWords];

	logic [7:0]  byte_d;
	logic [7:0]  len_byte;
	logic [31:0] w_mix;
	logic [31:0] w_new;
	logic [31:0] tmp;

	// Length bytes go out most significant first; fill positions 56..63 pick them.
	assign len_byte = 8'(len_q >> {~fill_q[2:0], 3'b000});

	always_comb begin
		case (cmd.src)
			sha1md_pkg::SRC_MSG:  byte_d = msg_byte;
			sha1md_pkg::SRC_PAD:  byte_d = sha1md_pkg::PadMark;
			sha1md_pkg::SRC_ZERO: byte_d = 8'h00;
			default:              byte_d = len_byte;
		endcase
	end

	// The window holds W[t..t+15]; the word appended each round is W[t+16].
	assign w_mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign w_new = {w_mix[30:0], w_mix[31]};

	assign tmp = {rv_q[0][26:0], rv_q[0][31:27]}
		+ sha1md_pkg::round_f(cmd.phase, rv_q[1], rv_q[2], rv_q[3])
		+ rv_q[4] + win_q[0] + sha1md_pkg::round_k(cmd.phase);

	assign stat.last_slot = (fill_q == 7'd63);
	assign stat.at_len    = (fill_q == 7'd56);
	assign digest_word    = chain_q[cmd.word_sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			for (int i = 0; i < sha1md_pkg::NumWords; i++) begin
				chain_q[i] <= sha1md_pkg::init_word(3'(i));
			end
		end else begin
			if (cmd.shift) begin
				fill_q <= fill_q + 7'd1;
			end else if (cmd.fin || cmd.reinit) begin
				fill_q <= '0;
			end
			if (cmd.reinit) begin
				len_q <= '0;
			end else if (cmd.count_len) begin
				len_q <= len_q + 64'd8;
			end
			for (int i = 0; i < sha1md_pkg::NumWords; i++) begin
				if (cmd.reinit) begin
					chain_q[i] <= sha1md_pkg::init_word(3'(i));
				end else if (cmd.fin) begin
					chain_q[i] <= chain_q[i] + rv_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int i = 0; i < sha1md_pkg::WinWords - 1; i++) begin
				win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
			end
			win_q[sha1md_pkg::WinWords-1] <= {win_q[sha1md_pkg::WinWords-1][23:0], byte_d};
		end else if (cmd.round) begin
			for (int i = 0; i < sha1md_pkg::WinWords - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[sha1md_pkg::WinWords-1] <= w_new;
		end
		if (cmd.load) begin
			for (int i = 0; i < sha1md_pkg::NumWords; i++) begin
				rv_q[i] <= chain_q[i];
			end
		end else if (cmd.round) begin
			rv_q[0] <= tmp;
			rv_q[1] <= rv_q[0];
			rv_q[2] <= {rv_q[1][1:0], rv_q[1][31:2]};
			rv_q[3] <= rv_q[2];
			rv_q[4] <= rv_q[3];
		end
	end

endmodule

// File: sv/sha1md_ctrl.sv
module sha1md_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                byte_present,
	input  logic                end_of_message,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          word_index,
	output logic                last_word,
	output sha1md_pkg::dp_cmd_t cmd,
	input  sha1md_pkg::dp_stat_t stat
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PAD80 = 8'b0000_0010,
		S_PADZ  = 8'b0000_0100,
		S_LEN   = 8'b0000_1000,
		S_LOAD  = 8'b0001_0000,
		S_COMP  = 8'b0010_0000,
		S_FIN   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	localparam logic [sha1md_pkg::RndW-1:0] LastRnd = sha1md_pkg::RndW'(sha1md_pkg::Rounds - 1);
	localparam logic [2:0] LastIdx = 3'(sha1md_pkg::NumWords - 1);

	state_t state_q, state_d;
	state_t ret_q, ret_d;
	logic [sha1md_pkg::RndW-1:0] rnd_q;
	logic [2:0] widx_q;
	logic       out_done;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign word_index = widx_q;
	assign last_word  = (widx_q == LastIdx);
	assign out_done   = out_valid && out_ready && (widx_q == LastIdx);

	always_comb begin
		state_d      = state_q;
		ret_d        = ret_q;
		cmd          = '0;
		cmd.src      = sha1md_pkg::SRC_MSG;
		cmd.word_sel = widx_q;
		if (rnd_q < 7'd20) begin
			cmd.phase = sha1md_pkg::PH_CHOOSE;
		end else if (rnd_q < 7'd40) begin
			cmd.phase = sha1md_pkg::PH_PARITY;
		end else if (rnd_q < 7'd60) begin
			cmd.phase = sha1md_pkg::PH_MAJOR;
		end else begin
			cmd.phase = sha1md_pkg::PH_LATE;
		end
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (byte_present) begin
						cmd.shift     = 1'b1;
						cmd.count_len = 1'b1;
					end
					// A byte that fills the block is compressed before any padding.
					if (byte_present && stat.last_slot) begin
						state_d = S_LOAD;
						ret_d   = end_of_message ? S_PAD80 : S_IDLE;
					end else if (end_of_message) begin
						state_d = S_PAD80;
					end
				end
			end
			S_PAD80: begin
				cmd.shift = 1'b1;
				cmd.src   = sha1md_pkg::SRC_PAD;
				ret_d     = S_PADZ;
				state_d   = stat.last_slot ? S_LOAD : S_PADZ;
			end
			S_PADZ: begin
				if (stat.at_len) begin
					state_d = S_LEN;
				end else begin
					cmd.shift = 1'b1;
					cmd.src   = sha1md_pkg::SRC_ZERO;
					if (stat.last_slot) begin
						state_d = S_LOAD;
						ret_d   = S_PADZ;
					end
				end
			end
			S_LEN: begin
				cmd.shift = 1'b1;
				cmd.src   = sha1md_pkg::SRC_LEN;
				if (stat.last_slot) begin
					state_d = S_LOAD;
					ret_d   = S_OUT;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_COMP;
			end
			S_COMP: begin
				cmd.round = 1'b1;
				if (rnd_q == LastRnd) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = ret_q;
			end
			S_OUT: begin
				if (out_done) begin
					cmd.reinit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			rnd_q   <= '0;
			widx_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (state_q == S_COMP && rnd_q != LastRnd) begin
				rnd_q <= rnd_q + sha1md_pkg::RndW'(1);
			end else begin
				rnd_q <= '0;
			end
			if (out_valid && out_ready) begin
				widx_q <= (widx_q == LastIdx) ? 3'd0 : widx_q + 3'd1;
			end
		end
	end

endmodule

// File: sv/sha1_message_digest.sv
// SHA-1 digest engine. Each input item carries at most one message byte; end_of_message
// closes the message, after which the five digest words h0..h4 leave as five output items
// (word_index 0..4, last_word on h4) and the engine starts over on a fresh message. A byte
// item is taken while the engine is idle. Every 64th byte starts a compression (one load,
// 80 rounds on the single round unit, one chaining add) during which no item is accepted.
// Closing a message shifts the padding and length into the block one byte per cycle while
// no compression runs, with a pause in the zero-padding state on reaching the length field,
// runs one or two compressions, then presents the digest words one per cycle as the sink
// takes them; no new item is accepted until h4 is taken.
module sha1_message_digest (
	input logic clk,
	input logic arst_n,
	sha1md_in_if.sink     msg_in,
	sha1md_out_if.source  digest_out
);

	sha1md_pkg::dp_cmd_t  cmd;
	sha1md_pkg::dp_stat_t stat;

	sha1md_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (msg_in.valid),
		.byte_present   (msg_in.byte_present),
		.end_of_message (msg_in.end_of_message),
		.in_ready       (msg_in.ready),
		.out_valid      (digest_out.valid),
		.out_ready      (digest_out.ready),
		.word_index     (digest_out.word_index),
		.last_word      (digest_out.last_word),
		.cmd            (cmd),
		.stat           (stat)
	);

	sha1md_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.msg_byte    (msg_in.msg_byte),
		.stat        (stat),
		.digest_word (digest_out.digest_word)
	);

endmodule
